// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed: %m");

`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen: %m");

`else

`define ASSERT_IMPLY(label, clk, rstn, ante, cons)

`define ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

// ===== sv/hild_pkg.sv =====
// Types and constants of the HPACK integer and literal decoder.
package hild_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CONT,
        PH_PAYLOAD
    } phase_t;

    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic [1:0] KIND_INT     = 2'd0;
    localparam logic [1:0] KIND_LEN     = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    localparam logic [5:0]  GROUP_BITS      = 6'd7;
    localparam logic [5:0]  WORD_BITS       = 6'd32;
    localparam logic [3:0]  LIT_PREFIX_BITS = 4'd7;
    localparam logic [31:0] MAX_LIT_RESET   = 32'd65536;

endpackage

// ===== sv/hpack_integer_literal_decoder_core.sv =====
// Byte-serial HPACK prefix integer and string literal decoder, top level.
// A result is registered and appears on the master side in the cycle after the byte's transfer.
// Throughput: one byte per cycle while no result is held or m_tready is high; the single result
// register drains while the next byte enters. Continuation bytes with bit 7 set yield only errors.
// Reset (aresetn low, synchronous) returns to idle, drops any held result, and
// restores max_literal_size to 65536.
`include "assert_macros.svh"

module hpack_integer_literal_decoder_core
    import hild_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // prefix_bits[3:0], data_byte[11:4], bytes_left[43:12], zeros
    input  logic [0:0]  s_tuser,   // cmd[0]
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], value[33:2], zeros
    output logic [2:0]  m_tuser,   // kind[1:0], huffman[2]
    output logic        m_tlast,
    // Configuration write channel for max_literal_size.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    // Input fields unpacked from the stream word.
    logic        in_cmd;
    logic [3:0]  in_prefix_bits;
    logic [7:0]  in_byte;
    logic [31:0] in_left;

    assign in_cmd         = s_tuser[0];
    assign in_prefix_bits = s_tdata[3:0];
    assign in_byte        = s_tdata[11:4];
    assign in_left        = s_tdata[43:12];

    // Decoder state.
    phase_t      phase_reg, phase_next;
    logic        lit_reg, lit_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  shift_reg, shift_next;
    logic        huff_reg, huff_next;
    logic [31:0] pay_left_reg, pay_left_next;
    logic [31:0] max_lit_reg;

    // Result register.
    logic        res_valid_reg, res_valid_next;
    logic [1:0]  res_status_reg;
    logic [1:0]  res_kind_reg;
    logic [31:0] res_value_reg;
    logic        res_huff_reg;
    logic        res_last_reg;

    // The block takes a byte whenever the result register is empty or is being
    // drained in the same cycle, so a stalled consumer throttles the input
    // without losing a cycle once it resumes.
    logic s_xfer;
    assign s_tready = !res_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    // The configuration register may be written at any time.
    assign cfg_ready = 1'b1;

    // Combinational decode of one byte against the current state.
    logic        emit_c;
    logic [1:0]  emit_status_c;
    logic [1:0]  emit_kind_c;
    logic [31:0] emit_value_c;
    logic        emit_huff_c;
    logic        emit_last_c;
    logic        fin_c;
    logic [31:0] fin_val_c;
    logic        err_c;
    logic [1:0]  err_code_c;
    logic        lit_c;
    logic        huff_c;
    logic [3:0]  nb_c;
    logic [7:0]  mask_c;
    logic [7:0]  v_c;
    logic [35:0] add_c;
    logic [35:0] sum_c;
    logic [31:0] pay_dec_c;

    always_comb begin
        phase_next    = phase_reg;
        lit_next      = lit_reg;
        acc_next      = acc_reg;
        shift_next    = shift_reg;
        huff_next     = huff_reg;
        pay_left_next = pay_left_reg;

        emit_c        = 1'b0;
        emit_status_c = ST_NONE;
        emit_kind_c   = KIND_INT;
        emit_value_c  = '0;
        emit_huff_c   = 1'b0;
        emit_last_c   = 1'b0;
        fin_c         = 1'b0;
        fin_val_c     = '0;
        err_c         = 1'b0;
        err_code_c    = ST_NONE;
        lit_c         = lit_reg;
        huff_c        = huff_reg;

        // A literal's length prefix is 7 bits; an integer's prefix width is
        // clamped into one to eight bits.
        if (in_cmd) begin
            nb_c = LIT_PREFIX_BITS;
        end else if (in_prefix_bits == 4'd0) begin
            nb_c = 4'd1;
        end else if (in_prefix_bits > 4'd8) begin
            nb_c = 4'd8;
        end else begin
            nb_c = in_prefix_bits;
        end
        mask_c = 8'hFF >> (4'd8 - nb_c);
        v_c    = in_byte & mask_c;

        // Exact continuation sum: the addend reaches at most 35 bits.
        add_c     = 36'(in_byte[6:0]) << shift_reg;
        sum_c     = {4'd0, acc_reg} + add_c;
        pay_dec_c = pay_left_reg - 32'd1;

        if (s_xfer) begin
            unique case (phase_reg)
                PH_PAYLOAD: begin
                    pay_left_next = pay_dec_c;
                    if (pay_dec_c == 32'd0) begin
                        phase_next = PH_IDLE;
                    end
                    emit_c       = 1'b1;
                    emit_kind_c  = KIND_PAYLOAD;
                    emit_value_c = {24'd0, in_byte};
                    emit_huff_c  = huff_reg;
                    emit_last_c  = (pay_dec_c == 32'd0);
                end
                PH_CONT: begin
                    if (shift_reg > WORD_BITS) begin
                        err_c      = 1'b1;
                        err_code_c = ST_OVERFLOW;
                    end else if (sum_c[35:32] != 4'd0) begin
                        err_c      = 1'b1;
                        err_code_c = ST_OVERFLOW;
                    end else begin
                        acc_next   = sum_c[31:0];
                        shift_next = shift_reg + GROUP_BITS;
                        if (in_byte[7]) begin
                            if (in_left == 32'd0) begin
                                err_c      = 1'b1;
                                err_code_c = ST_UNDERFLOW;
                            end
                        end else begin
                            fin_c     = 1'b1;
                            fin_val_c = sum_c[31:0];
                        end
                    end
                end
                default: begin
                    // First byte of a field.
                    lit_c     = in_cmd;
                    huff_c    = in_cmd & in_byte[7];
                    lit_next  = lit_c;
                    huff_next = huff_c;
                    if (v_c != mask_c) begin
                        fin_c     = 1'b1;
                        fin_val_c = {24'd0, v_c};
                    end else begin
                        acc_next   = {24'd0, v_c};
                        shift_next = '0;
                        phase_next = PH_CONT;
                        if (in_left == 32'd0) begin
                            err_c      = 1'b1;
                            err_code_c = ST_UNDERFLOW;
                        end
                    end
                end
            endcase

            // A complete integer: report it, or check a literal length.
            if (fin_c) begin
                phase_next = PH_IDLE;
                if (!lit_c) begin
                    emit_c       = 1'b1;
                    emit_value_c = fin_val_c;
                    emit_last_c  = 1'b1;
                end else if (fin_val_c > in_left) begin
                    err_c      = 1'b1;
                    err_code_c = ST_UNDERFLOW;
                end else if (fin_val_c > max_lit_reg) begin
                    err_c      = 1'b1;
                    err_code_c = ST_TOO_LARGE;
                end else begin
                    if (fin_val_c != 32'd0) begin
                        phase_next    = PH_PAYLOAD;
                        pay_left_next = fin_val_c;
                    end
                    emit_c       = 1'b1;
                    emit_kind_c  = KIND_LEN;
                    emit_value_c = fin_val_c;
                    emit_huff_c  = huff_c;
                    emit_last_c  = (fin_val_c == 32'd0);
                end
            end

            // Every error closes the field and returns to idle.
            if (err_c) begin
                phase_next    = PH_IDLE;
                emit_c        = 1'b1;
                emit_status_c = err_code_c;
                emit_kind_c   = lit_c ? KIND_LEN : KIND_INT;
                emit_value_c  = '0;
                emit_huff_c   = lit_c & huff_c;
                emit_last_c   = 1'b1;
            end
        end

        if (s_xfer) begin
            res_valid_next = emit_c;
        end else if (m_tready) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            lit_reg       <= 1'b0;
            acc_reg       <= '0;
            shift_reg     <= '0;
            huff_reg      <= 1'b0;
            pay_left_reg  <= '0;
            max_lit_reg   <= MAX_LIT_RESET;
            res_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            lit_reg       <= lit_next;
            acc_reg       <= acc_next;
            shift_reg     <= shift_next;
            huff_reg      <= huff_next;
            pay_left_reg  <= pay_left_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready) begin
                max_lit_reg <= cfg_data;
            end
        end
    end

    // Result payload needs no reset; it loads only with a new result.
    always_ff @(posedge aclk) begin
        if (s_xfer && emit_c) begin
            res_status_reg <= emit_status_c;
            res_kind_reg   <= emit_kind_c;
            res_value_reg  <= emit_value_c;
            res_huff_reg   <= emit_huff_c;
            res_last_reg   <= emit_last_c;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {6'd0, res_value_reg, res_status_reg};
    assign m_tuser  = {res_huff_reg, res_kind_reg};
    assign m_tlast  = res_last_reg;

    // While payload bytes are expected, at least one is still owed.
    `ASSERT_IMPLY(a_payload_owed, aclk, aresetn, phase_reg == PH_PAYLOAD, pay_left_reg != 32'd0)

    // The continuation shift only ever steps through multiples of seven.
    `ASSERT_IMPLY(a_shift_steps, aclk, aresetn, phase_reg == PH_CONT,
        shift_reg == 6'd0 || shift_reg == 6'd7 || shift_reg == 6'd14 ||
        shift_reg == 6'd21 || shift_reg == 6'd28 || shift_reg == 6'd35)

    // An error always ends the field and carries a zero value.
    `ASSERT_IMPLY(a_error_closes, aclk, aresetn, m_tvalid && res_status_reg != ST_NONE,
        m_tlast && res_value_reg == 32'd0)

    // Payload byte results never carry a value wider than a byte.
    `ASSERT_IMPLY(a_payload_byte, aclk, aresetn, m_tvalid && res_kind_reg == KIND_PAYLOAD,
        res_value_reg[31:8] == 24'd0 && res_status_reg == ST_NONE)

    // The kind code 3 is never produced.
    `ASSERT_NEVER(a_kind_code, aclk, aresetn, m_tvalid && res_kind_reg == 2'd3)

endmodule

// ===== bench/tb_hpack_integer_literal_decoder_core.sv =====
// Self-checking testbench for the byte-serial HPACK integer and string literal decoder.
module tb_hpack_integer_literal_decoder_core;
    import hild_pkg::*;

    localparam int ITEM_TARGET  = 1350;
    localparam int PHASES       = 5;
    localparam int STALL_LIMIT  = 3000;
    localparam int REPORT_LIMIT = 10;

    // One decoded result, in the order the fields are compared.
    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  kind;
        logic [31:0] value;
        logic        huffman;
        logic        last;
    } decode_result_t;

    // Tracks the decoder's field state and holds the results it must still produce.
    class hpack_decode_tracker;
        phase_t         phase;
        bit             field_is_literal;
        bit [31:0]      accumulator;
        bit [5:0]       shift_amount;
        bit             huffman_flag;
        bit [31:0]      payload_left;
        bit [31:0]      max_literal_size;
        decode_result_t pending_results[$];
        int             mismatches;

        function new();
            phase            = PH_IDLE;
            field_is_literal = 1'b0;
            accumulator      = '0;
            shift_amount     = '0;
            huffman_flag     = 1'b0;
            payload_left     = '0;
            max_literal_size = MAX_LIT_RESET;
            mismatches       = 0;
        endfunction

        function void post(logic [1:0] status, logic [1:0] kind, logic [31:0] value,
                           bit huffman, bit last);
            decode_result_t r;
            r.status  = status;
            r.kind    = kind;
            r.value   = value;
            r.huffman = huffman;
            r.last    = last;
            pending_results.push_back(r);
        endfunction

        // An error ends the field; the kind tells which field type was open.
        function void abort_field(logic [1:0] status);
            phase = PH_IDLE;
            post(status, field_is_literal ? KIND_LEN : KIND_INT, 32'd0,
                 field_is_literal ? huffman_flag : 1'b0, 1'b1);
        endfunction

        function void close_field(bit [31:0] v, bit [31:0] left);
            phase = PH_IDLE;
            if (!field_is_literal) begin
                post(ST_NONE, KIND_INT, v, 1'b0, 1'b1);
            end else if (v > left) begin
                abort_field(ST_UNDERFLOW);
            end else if (v > max_literal_size) begin
                abort_field(ST_TOO_LARGE);
            end else begin
                if (v != 0) begin
                    phase        = PH_PAYLOAD;
                    payload_left = v;
                end
                post(ST_NONE, KIND_LEN, v, huffman_flag, v == 0);
            end
        endfunction

        function void take_byte(bit cmd, bit [3:0] prefix_bits, bit [7:0] data_byte,
                                bit [31:0] bytes_left);
            bit [3:0]  width;
            bit [7:0]  mask;
            bit [63:0] sum;
            case (phase)
                PH_PAYLOAD: begin
                    payload_left--;
                    if (payload_left == 0)
                        phase = PH_IDLE;
                    post(ST_NONE, KIND_PAYLOAD, {24'd0, data_byte}, huffman_flag,
                         payload_left == 0);
                end
                PH_CONT: begin
                    if (shift_amount > WORD_BITS) begin
                        abort_field(ST_OVERFLOW);
                    end else begin
                        sum = {32'd0, accumulator} + ({57'd0, data_byte[6:0]} << shift_amount);
                        if (sum[63:32] != 0) begin
                            abort_field(ST_OVERFLOW);
                        end else begin
                            accumulator  = sum[31:0];
                            shift_amount = shift_amount + GROUP_BITS;
                            if (data_byte[7]) begin
                                if (bytes_left == 0)
                                    abort_field(ST_UNDERFLOW);
                            end else begin
                                close_field(accumulator, bytes_left);
                            end
                        end
                    end
                end
                default: begin
                    field_is_literal = cmd;
                    if (cmd) begin
                        huffman_flag = data_byte[7];
                        width        = LIT_PREFIX_BITS;
                    end else begin
                        huffman_flag = 1'b0;
                        width = (prefix_bits == 4'd0) ? 4'd1 :
                                ((prefix_bits > 4'd8) ? 4'd8 : prefix_bits);
                    end
                    mask = 8'hFF >> (4'd8 - width);
                    if ((data_byte & mask) != mask) begin
                        close_field({24'd0, data_byte & mask}, bytes_left);
                    end else begin
                        accumulator  = {24'd0, mask};
                        shift_amount = '0;
                        phase        = PH_CONT;
                        if (bytes_left == 0)
                            abort_field(ST_UNDERFLOW);
                    end
                end
            endcase
        endfunction

        function void match_result(decode_result_t got);
            decode_result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: status %0d kind %0d value %h huffman %0b last %0b",
                             got.status, got.kind, got.value, got.huffman, got.last);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.kind !== want.kind ||
                got.value !== want.value || got.huffman !== want.huffman ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result mismatch: expected status %0d kind %0d value %h huffman %0b last %0b, got status %0d kind %0d value %h huffman %0b last %0b",
                             want.status, want.kind, want.value, want.huffman, want.last,
                             got.status, got.kind, got.value, got.huffman, got.last);
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    hpack_decode_tracker tracker = new();
    bit [7:0]            field_bytes[$];
    int                  items_sent   = 0;
    int                  burst_left   = 0;
    int                  quiet_cycles = 0;
    int unsigned         ready_tick   = 0;

    hpack_integer_literal_decoder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The receiver cycles through its own stall patterns, selected by ready_tick[10:9].
    always @(posedge aclk) begin
        ready_tick <= ready_tick + 1;
        case (ready_tick[10:9])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ready_tick[2:0] != 3'd5 && ready_tick[2:0] != 3'd6;
            2'd2: m_tready <= ready_tick[1:0] == 2'd0;
            default: m_tready <= $urandom_range(0, 2) != 0;
        endcase
    end

    // Outputs are settled at the falling edge and hold until the transfer edge.
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.match_result({m_tdata[1:0], m_tuser[1:0], m_tdata[33:2], m_tuser[2], m_tlast});
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_byte(bit cmd, bit [3:0] prefix_bits, bit [7:0] data_byte,
                             bit [31:0] bytes_left);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, bytes_left, data_byte, prefix_bits};
        s_tuser  <= cmd;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        tracker.take_byte(cmd, prefix_bits, data_byte, bytes_left);
        items_sent++;
    endtask

    // Inside a literal's length the buffer count is kept small, so payloads stay short.
    function automatic bit [31:0] loose_left();
        if (tracker.phase == PH_CONT && tracker.field_is_literal)
            return $urandom_range(0, 400);
        return $urandom;
    endfunction

    task automatic stream_payload();
        while (tracker.phase == PH_PAYLOAD)
            send_byte(1'($urandom), 4'($urandom), 8'($urandom), $urandom);
    endtask

    task automatic close_open_field();
        while (tracker.phase != PH_IDLE) begin
            if (tracker.phase == PH_PAYLOAD)
                stream_payload();
            else
                send_byte(1'($urandom), 4'($urandom), 8'($urandom) & 8'h7F, loose_left());
        end
    endtask

    function automatic void build_prefix_int(int width, bit [31:0] value, bit [7:0] high_bits);
        bit [7:0]  mask;
        bit [31:0] rest;
        mask = 8'hFF >> (8 - width);
        field_bytes.delete();
        if (value < mask) begin
            field_bytes.push_back((high_bits & ~mask) | value[7:0]);
        end else begin
            field_bytes.push_back(high_bits | mask);
            rest = value - mask;
            while (rest >= 128) begin
                field_bytes.push_back({1'b1, rest[6:0]});
                rest = rest >> 7;
            end
            field_bytes.push_back({1'b0, rest[6:0]});
        end
    endfunction

    // Sends the encoded field; tail counts the payload bytes that follow the length.
    task automatic send_queued_field(bit cmd, bit [3:0] prefix_bits, int unsigned tail,
                                     bit starve);
        int unsigned needed;
        bit [31:0]   left;
        for (int i = 0; i < field_bytes.size(); i++) begin
            if (i > 0 && tracker.phase != PH_CONT)
                break;
            needed = field_bytes.size() - 1 - i + tail;
            if (starve && needed > 0)
                left = $urandom_range(0, needed - 1);
            else if ($urandom_range(0, 7) == 0)
                left = needed + $urandom;
            else
                left = needed + $urandom_range(0, 3);
            send_byte(cmd, prefix_bits, field_bytes[i], left);
        end
        stream_payload();
    endtask

    task automatic send_random_integer();
        bit [3:0]  width_field;
        int        width;
        bit [7:0]  mask;
        bit [31:0] value;
        int        pick;
        width_field = 4'($urandom);
        width = (width_field == 0) ? 1 : ((width_field > 8) ? 8 : width_field);
        mask  = 8'hFF >> (8 - width);
        pick  = $urandom_range(0, 19);
        if (pick < 8)
            value = $urandom_range(0, mask);
        else if (pick < 13)
            value = $urandom_range(0, 400);
        else if (pick < 16)
            value = $urandom_range(0, 1 << 21);
        else if (pick < 19)
            value = $urandom;
        else
            value = 32'hFFFF_FFFF;
        build_prefix_int(width, value, 8'($urandom));
        send_queued_field(1'b0, width_field, 0, $urandom_range(0, 9) == 0);
    endtask

    task automatic send_random_literal();
        int unsigned len;
        int          pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            len = $urandom_range(0, 16);
        else if (pick < 17)
            len = $urandom_range(100, 300);
        else if (tracker.max_literal_size < 32'hFFFF_0000)
            len = tracker.max_literal_size + $urandom_range(1, 3);
        else
            len = 127;
        build_prefix_int(7, len, {1'($urandom), 7'd0});
        send_queued_field(1'b1, 4'($urandom), len, $urandom_range(0, 9) == 0);
    endtask

    // An all-ones prefix and several continuation groups may overflow the sum or the shift range.
    task automatic send_overflow_run();
        int k;
        k = $urandom_range(3, 6);
        send_byte(1'b0, 4'($urandom), 8'hFF, $urandom_range(1, 1000));
        repeat (k) begin
            if (tracker.phase == PH_CONT)
                send_byte(1'($urandom), 4'($urandom), 8'h80 | 8'($urandom), $urandom | 1);
        end
        if (tracker.phase == PH_CONT)
            send_byte(1'($urandom), 4'($urandom), 8'($urandom), $urandom);
    endtask

    // Literals right at the limit when it is at most 300, and one byte beyond it unless it is all ones.
    task automatic probe_literal_limit(bit [31:0] limit);
        if (limit <= 300) begin
            build_prefix_int(7, limit, {1'($urandom), 7'd0});
            send_queued_field(1'b1, 4'($urandom), limit, 1'b0);
        end
        if (limit != 32'hFFFF_FFFF) begin
            build_prefix_int(7, limit + 1, {1'($urandom), 7'd0});
            send_queued_field(1'b1, 4'($urandom), limit + 1, 1'b0);
        end
    endtask

    task automatic drain_results();
        close_open_field();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending_results.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_max_literal(bit [31:0] limit);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        tracker.max_literal_size = limit;
    endtask

    initial begin
        bit [31:0] limits[PHASES];
        int        directed_items;
        int        pick;
        limits[0] = 32'd0;
        limits[1] = 32'hFFFF_FFFF;
        limits[2] = $urandom_range(1, 40);
        limits[3] = MAX_LIT_RESET;
        limits[4] = $urandom_range(100, 250);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed fields, decoded under the reset literal limit.
        send_byte(1'b0, 4'd5, 8'h0A, 32'd3);           // value fits the prefix
        send_byte(1'b0, 4'd0, 8'hFE, 32'd0);           // prefix width zero acts as one
        send_byte(1'b0, 4'd15, 8'hFE, 32'hFFFF_FFFF);  // prefix width above eight acts as eight
        build_prefix_int(5, 1337, 8'h00);
        send_queued_field(1'b0, 4'd5, 0, 1'b0);
        send_byte(1'b0, 4'd4, 8'h0F, 32'd0);           // continuation wanted with nothing left
        send_byte(1'b0, 4'd3, 8'h07, 32'd5);
        send_byte(1'b0, 4'd3, 8'h85, 32'd0);           // group asks for more at buffer end
        send_byte(1'b0, 4'd1, 8'h01, 32'd9);
        repeat (5) send_byte(1'b0, 4'd1, 8'h80, 32'd9);
        send_byte(1'b0, 4'd1, 8'h00, 32'd9);           // group arrives at shift 35
        send_byte(1'b0, 4'd8, 8'hFF, 32'd6);
        repeat (4) send_byte(1'b0, 4'd8, 8'hFF, 32'd6);
        send_byte(1'b0, 4'd8, 8'h7F, 32'd6);           // sum spills past 32 bits
        send_byte(1'b1, 4'd2, 8'h82, 32'd2);           // Huffman literal of two bytes
        send_byte(1'b0, 4'd9, 8'h00, 32'd0);
        send_byte(1'b1, 4'd0, 8'hFF, 32'hFFFF_FFFF);
        send_byte(1'b1, 4'd0, 8'h80, 32'd0);           // empty literal ends at once
        send_byte(1'b1, 4'd8, 8'h85, 32'd4);           // length beyond the buffer
        build_prefix_int(7, 70000, 8'h00);
        send_queued_field(1'b1, 4'd0, 70000, 1'b0);    // length beyond the limit
        directed_items = items_sent;
        drain_results();

        // Random traffic in several limit settings; each write waits for an idle decoder.
        for (int p = 0; p < PHASES; p++) begin
            write_max_literal(limits[p]);
            probe_literal_limit(limits[p]);
            while (items_sent < directed_items + (p + 1) * ITEM_TARGET / PHASES) begin
                close_open_field();
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    send_random_integer();
                else if (pick < 80)
                    send_random_literal();
                else if (pick < 90)
                    send_overflow_run();
                else
                    send_byte(1'($urandom), 4'($urandom), 8'($urandom), loose_left());
            end
            drain_results();
        end

        if (tracker.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
